// ===== src/pwmmd_pkg.sv =====
package pwmmd_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int STEP_WIDTH = 16;
  localparam int DUTY_WIDTH = STEP_WIDTH + 1;
  localparam int PROD_WIDTH = TIME_WIDTH + STEP_WIDTH;
  localparam int CNT_WIDTH = $clog2(PROD_WIDTH);
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DUTY_MIN = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DUTY_MAX = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RESOLUTION = CFG_IDX_WIDTH'(3);

  localparam logic [TIME_WIDTH-1:0] PERIOD_RESET = TIME_WIDTH'(1000);
  localparam logic [TIME_WIDTH-1:0] DUTY_MIN_RESET = TIME_WIDTH'(0);
  localparam logic [TIME_WIDTH-1:0] DUTY_MAX_RESET = TIME_WIDTH'(1000);
  localparam logic [STEP_WIDTH-1:0] RESOLUTION_RESET = STEP_WIDTH'(100);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET_DUTY = 1'b1;

  typedef struct packed {
    logic tick;
    logic capture;
    logic mult;
    logic div_step;
    logic commit;
    logic out_load;
  } pwmmd_cmd_t;

  typedef struct packed {
    logic div_done;
  } pwmmd_sts_t;

endpackage

// ===== src/pwmmd_in_if.sv =====
interface pwmmd_in_if;
  import pwmmd_pkg::*;

  logic valid;
  logic ready;
  logic mode;
  logic signed [DUTY_WIDTH-1:0] duty;

  modport source (output valid, output mode, output duty, input ready);
  modport sink (input valid, input mode, input duty, output ready);
endinterface

// ===== src/pwmmd_out_if.sv =====
interface pwmmd_out_if;
  logic valid;
  logic ready;
  logic level;
  logic config_ok;

  modport source (output valid, output level, output config_ok, input ready);
  modport sink (input valid, input level, input config_ok, output ready);
endinterface

// ===== src/pwm_generator_min_max_duty.sv =====
// PWM generator whose high time is scaled between a minimum and a maximum.
// Words enter on in_if: mode 0 is one tick, mode 1 sets a new duty value.
// Every input word returns exactly one word on out_if, carrying the PWM level
// after that word and the config_ok flag for the current registers.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must
// write them only while the block is idle, which the block itself does not enforce.
// A tick word is answered in the cycle after it is accepted, and a tick can be
// accepted in every cycle while the output is taken, so ticks run at one
// per cycle.
// A set-duty word is answered after these steps: the duty is clamped and captured,
// the span times duty product is formed, the 48-bit product is divided by the
// resolution bit-serially, the delays are updated and the output is loaded once
// the output is free. No word is accepted during that time.
// Reset gives the idle level, a zero count, zero delays and the register
// defaults. When the receiver stalls, the pending word holds on out_if and
// one further word is not accepted until it has been taken.
module pwm_generator_min_max_duty (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwmmd_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [pwmmd_pkg::TIME_WIDTH-1:0]    cfg_wdata_i,
  pwmmd_in_if.sink                            in_if,
  pwmmd_out_if.source                         out_if
);
  import pwmmd_pkg::*;

  pwmmd_cmd_t cmd;
  pwmmd_sts_t sts;

  pwmmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_mode_i   (in_if.mode),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pwmmd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .duty_i      (in_if.duty),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .level_o     (out_if.level),
    .config_ok_o (out_if.config_ok)
  );

endmodule

// ===== src/pwmmd_ctrl.sv =====
module pwmmd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_mode_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  pwmmd_pkg::pwmmd_sts_t  sts_i,
  output pwmmd_pkg::pwmmd_cmd_t  cmd_o
);
  import pwmmd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_FIN = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_SET_DUTY) begin
            cmd_o.capture = 1'b1;
            state_d = ST_MUL;
          end else begin
            cmd_o.tick = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mult = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/pwmmd_dp.sv =====
module pwmmd_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pwmmd_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [pwmmd_pkg::TIME_WIDTH-1:0]      cfg_wdata_i,
  input  logic signed [pwmmd_pkg::DUTY_WIDTH-1:0] duty_i,
  input  pwmmd_pkg::pwmmd_cmd_t                 cmd_i,
  output pwmmd_pkg::pwmmd_sts_t                 sts_o,
  output logic                                  level_o,
  output logic                                  config_ok_o
);
  import pwmmd_pkg::*;

  logic [TIME_WIDTH-1:0] period_q, duty_min_q, duty_max_q;
  logic [STEP_WIDTH-1:0] res_q;
  logic                  phase_q, phase_d;
  logic [TIME_WIDTH-1:0] ticks_q, ticks_d;
  logic [TIME_WIDTH-1:0] high_q, low_q, high_d, low_d;
  logic [STEP_WIDTH-1:0] duty_q, duty_clamp;
  logic [PROD_WIDTH-1:0] num_q, prod;
  logic [STEP_WIDTH-1:0] rem_q;
  logic [CNT_WIDTH-1:0]  cnt_q;
  logic [STEP_WIDTH:0]   trial;
  logic                  qbit;
  logic [TIME_WIDTH-1:0] span, term;
  logic                  cfg_ok;
  logic                  level_q, config_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      duty_min_q <= DUTY_MIN_RESET;
      duty_max_q <= DUTY_MAX_RESET;
      res_q <= RESOLUTION_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD: period_q <= cfg_wdata_i;
        REG_DUTY_MIN: duty_min_q <= cfg_wdata_i;
        REG_DUTY_MAX: duty_max_q <= cfg_wdata_i;
        REG_RESOLUTION: res_q <= cfg_wdata_i[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ok = (res_q != '0) && (period_q != '0) &&
                  (duty_max_q <= period_q) && (duty_min_q < duty_max_q);

  always_comb begin
    if (duty_i[DUTY_WIDTH-1]) begin
      duty_clamp = '0;
    end else if (duty_i[STEP_WIDTH-1:0] > res_q) begin
      duty_clamp = res_q;
    end else begin
      duty_clamp = duty_i[STEP_WIDTH-1:0];
    end
  end

  assign span = (duty_max_q > duty_min_q) ? (duty_max_q - duty_min_q) : '0;
  assign prod = PROD_WIDTH'(span) * PROD_WIDTH'(duty_q);

  assign trial = {rem_q, num_q[PROD_WIDTH-1]};
  assign qbit = (trial >= {1'b0, res_q});
  assign sts_o.div_done = (cnt_q == CNT_WIDTH'(PROD_WIDTH - 1));

  assign term = (res_q == '0) ? '0 : num_q[TIME_WIDTH-1:0];
  assign high_d = duty_min_q + term;
  assign low_d = (period_q > high_d) ? (period_q - high_d) : '0;

  always_comb begin
    if (ticks_q == '0) begin
      phase_d = !phase_q;
      ticks_d = phase_d ? high_q : low_q;
    end else begin
      phase_d = phase_q;
      ticks_d = ticks_q - TIME_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      duty_q <= duty_clamp;
    end
    if (cmd_i.mult) begin
      num_q <= prod;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[PROD_WIDTH-2:0], qbit};
      rem_q <= qbit ? STEP_WIDTH'(trial - {1'b0, res_q}) : trial[STEP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      phase_q <= 1'b0;
      ticks_q <= '0;
      high_q <= '0;
      low_q <= '0;
      level_q <= 1'b0;
      config_ok_q <= 1'b0;
    end else begin
      if (cmd_i.mult) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_WIDTH'(1);
      end
      if (cmd_i.commit) begin
        high_q <= high_d;
        low_q <= low_d;
      end
      if (cmd_i.tick) begin
        phase_q <= phase_d;
        ticks_q <= ticks_d;
        level_q <= phase_d;
        config_ok_q <= cfg_ok;
      end else if (cmd_i.out_load) begin
        level_q <= phase_q;
        config_ok_q <= cfg_ok;
      end
    end
  end

  assign level_o = level_q;
  assign config_ok_o = config_ok_q;

endmodule

// ===== src/pwmmd_checker.sv =====
module pwmmd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_level
);
  import pwmmd_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("Output word dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == MODE_TICK) |=> out_valid)
    else $error("Tick word not answered in the next cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == MODE_SET_DUTY) |=> !in_ready)
    else $error("Input accepted while a duty update is in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(out_level) |-> $past(in_valid && in_ready && (in_mode == MODE_TICK)))
    else $error("Level changed without a tick word.");

endmodule

bind pwm_generator_min_max_duty pwmmd_checker u_pwmmd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_mode   (in_if.mode),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_level (out_if.level)
);

// ===== tb/pwm_generator_min_max_duty_tb.sv =====
`timescale 1ns / 100ps

module pwm_generator_min_max_duty_tb;
  import pwmmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AFTER = 150;
  localparam int SETTLE_CYCLES = 60;

  typedef logic signed [DUTY_WIDTH-1:0] duty_t;

  typedef struct packed {
    logic level;
    logic config_ok;
  } pwm_status_t;

  class pwm_scoreboard;
    logic [TIME_WIDTH-1:0] win_period = PERIOD_RESET;
    logic [TIME_WIDTH-1:0] win_min = DUTY_MIN_RESET;
    logic [TIME_WIDTH-1:0] win_max = DUTY_MAX_RESET;
    logic [STEP_WIDTH-1:0] steps = RESOLUTION_RESET;
    logic busy = 1'b0;
    logic [TIME_WIDTH-1:0] countdown = '0;
    logic [TIME_WIDTH-1:0] busy_len = '0;
    logic [TIME_WIDTH-1:0] idle_len = '0;
    pwm_status_t expected_status[$];
    int words = 0;
    int duty_updates = 0;
    int toggles = 0;
    int checked = 0;
    int ok_high = 0;
    int ok_low = 0;
    int failures = 0;

    function logic window_ok();
      return steps != 0 && win_period != 0 && win_max <= win_period && win_min < win_max;
    endfunction

    function void apply_word(logic mode, duty_t duty);
      logic [63:0] req;
      logic [63:0] span;
      logic [63:0] scaled;
      pwm_status_t st;
      words++;
      if (mode == MODE_SET_DUTY) begin
        duty_updates++;
        req = duty[DUTY_WIDTH-1] ? 64'd0 : 64'(duty[DUTY_WIDTH-2:0]);
        if (req > 64'(steps)) req = 64'(steps);
        span = (win_max > win_min) ? 64'(win_max - win_min) : 64'd0;
        scaled = (steps != 0) ? (span * req) / 64'(steps) : 64'd0;
        busy_len = TIME_WIDTH'(64'(win_min) + scaled);
        idle_len = (win_period > busy_len) ? win_period - busy_len : '0;
      end else if (countdown == 0) begin
        busy = ~busy;
        toggles++;
        countdown = busy ? busy_len : idle_len;
      end else begin
        countdown = countdown - TIME_WIDTH'(1);
      end
      st.level = busy;
      st.config_ok = window_ok();
      expected_status.push_back(st);
    endfunction

    task report(string what);
      failures++;
      if (failures <= 20) $display("MISMATCH at word %0d: %s", checked, what);
    endtask

    task check_status(logic level, logic config_ok);
      pwm_status_t want;
      checked++;
      if (config_ok) ok_high++;
      else ok_low++;
      if (expected_status.size() == 0) begin
        report($sformatf("unexpected word level=%0b config_ok=%0b", level, config_ok));
      end else begin
        want = expected_status.pop_front();
        if (level !== want.level)
          report($sformatf("level %0b, expected %0b", level, want.level));
        if (config_ok !== want.config_ok)
          report($sformatf("config_ok %0b, expected %0b", config_ok, want.config_ok));
      end
    endtask

    task check_drained();
      if (expected_status.size() != 0)
        report($sformatf("%0d words never arrived", expected_status.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [TIME_WIDTH-1:0] cfg_wdata_i;

  pwmmd_in_if in_bus ();
  pwmmd_out_if out_bus ();

  pwm_scoreboard sb;
  int burst_left;
  int phases;
  int cycle_count;

  pwm_generator_min_max_duty DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) sb.apply_word(in_bus.mode, in_bus.duty);
      if (out_bus.valid && out_bus.ready) sb.check_status(out_bus.level, out_bus.config_ok);
    end
  end

  // The receiver switches between stall styles and holds off once for a long stretch.
  initial begin : receiver
    int taken;
    int hold_left;
    int style;
    int span_left;
    bit held;
    taken = 0;
    hold_left = 0;
    style = 0;
    span_left = 0;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) taken++;
      if (!held && taken == HOLD_AFTER) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (span_left == 0) begin
        style = $urandom_range(0, 3);
        span_left = $urandom_range(16, 80);
      end
      span_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (style)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 9) < 7);
          2: out_bus.ready <= (span_left % 3 != 0);
          default: out_bus.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("Timeout after %0d cycles.", CYCLE_LIMIT);
    $display("pwm_generator_min_max_duty test failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [TIME_WIDTH-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_PERIOD: sb.win_period = data;
      REG_DUTY_MIN: sb.win_min = data;
      REG_DUTY_MAX: sb.win_max = data;
      REG_RESOLUTION: sb.steps = data[STEP_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [TIME_WIDTH-1:0] period,
                              input logic [TIME_WIDTH-1:0] lo,
                              input logic [TIME_WIDTH-1:0] hi,
                              input logic [STEP_WIDTH-1:0] res);
    write_reg(REG_PERIOD, period);
    write_reg(REG_DUTY_MIN, lo);
    write_reg(REG_DUTY_MAX, hi);
    write_reg(REG_RESOLUTION, (TIME_WIDTH'($urandom) & ~TIME_WIDTH'({STEP_WIDTH{1'b1}})) |
              TIME_WIDTH'(res));
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  task automatic send_word(input logic mode, input duty_t duty);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.mode <= mode;
    in_bus.duty <= duty;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_status.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic duty_t pick_duty(logic [STEP_WIDTH-1:0] res);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return duty_t'($urandom_range(0, int'(res)));
    if (pick < 6) return duty_t'($urandom_range(int'(res), 65535));
    if (pick < 8) return duty_t'(-int'($urandom_range(1, 65536)));
    return duty_t'($urandom);
  endfunction

  task automatic run_words(input int count, input int set_pct, input int pause_at);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) wait_idle();
      if ($urandom_range(0, 99) < set_pct) send_word(MODE_SET_DUTY, pick_duty(sb.steps));
      else send_word(MODE_TICK, duty_t'($urandom));
    end
    wait_idle();
  endtask

  initial begin : stimulus
    logic [TIME_WIDTH-1:0] period;
    logic [TIME_WIDTH-1:0] lo;
    logic [TIME_WIDTH-1:0] hi;
    logic [STEP_WIDTH-1:0] res;
    int ph;
    sb = new();
    burst_left = 0;
    phases = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= MODE_TICK;
    in_bus.duty <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With zero delays after reset every tick toggles the level.
    repeat (3) send_word(MODE_TICK, '0);
    send_word(MODE_SET_DUTY, duty_t'(-65536));
    send_word(MODE_SET_DUTY, duty_t'(65535));
    send_word(MODE_SET_DUTY, duty_t'(0));
    send_word(MODE_SET_DUTY, duty_t'(100));
    send_word(MODE_SET_DUTY, duty_t'(101));
    send_word(MODE_SET_DUTY, duty_t'(-1));
    send_word(MODE_SET_DUTY, duty_t'(50));
    wait_idle();
    apply_config(32'd8, 32'd2, 32'd6, 16'd4);
    send_word(MODE_SET_DUTY, duty_t'(2));
    repeat (8) send_word(MODE_TICK, duty_t'($urandom));
    send_word(MODE_SET_DUTY, duty_t'(7));
    repeat (3) send_word(MODE_TICK, duty_t'($urandom));
    wait_idle();
    // Zero resolution, maximum below minimum and a high time beyond the period.
    apply_config(32'd5, 32'd7, 32'd3, 16'd0);
    send_word(MODE_SET_DUTY, duty_t'(3));
    repeat (2) send_word(MODE_TICK, duty_t'($urandom));
    wait_idle();

    for (ph = 0; ph < 14; ph++) begin
      if ($urandom_range(0, 9) < 6) begin
        period = $urandom_range(4, 40);
        hi = $urandom_range(1, int'(period));
        lo = $urandom_range(0, int'(hi) - 1);
        res = STEP_WIDTH'($urandom_range(1, 20));
      end else begin
        period = $urandom_range(0, 40);
        lo = $urandom_range(0, 40);
        hi = $urandom_range(0, 40);
        res = ($urandom_range(0, 3) == 0) ? '1 : STEP_WIDTH'($urandom_range(0, 20));
      end
      apply_config(period, lo, hi, res);
      run_words(28, 12, (ph == 4) ? 14 : -1);
    end

    // Full-width windows last, since they load counts that never run out.
    apply_config('1, '0, '1, '1);
    run_words(12, 60, -1);
    apply_config('1, 32'hFFFF_FFFE, '1, 16'd1);
    run_words(10, 60, -1);
    apply_config('0, '1, '0, '0);
    run_words(10, 60, -1);
    apply_config($urandom, $urandom, $urandom, STEP_WIDTH'($urandom));
    run_words(12, 60, -1);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.check_drained();
    $display("Covered %0d words (%0d duty updates) over %0d register settings, %0d toggles.",
             sb.words, sb.duty_updates, phases, sb.toggles);
    $display("Results checked: %0d, config_ok high %0d and low %0d times, %0d mismatches.",
             sb.checked, sb.ok_high, sb.ok_low, sb.failures);
    if (sb.failures == 0) $display("pwm_generator_min_max_duty test passed");
    else $display("pwm_generator_min_max_duty test failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/pwmmd_pkg.sv
src/pwmmd_in_if.sv
src/pwmmd_out_if.sv
src/pwmmd_ctrl.sv
src/pwmmd_dp.sv
src/pwm_generator_min_max_duty.sv
src/pwmmd_checker.sv
tb/pwm_generator_min_max_duty_tb.sv
